FILE: rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the timestamped pattern player.
// ----------------------------------------------------------------------------
package tpp_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int PTR_W       = $clog2(TABLE_DEPTH);
  localparam int PIN_COUNT   = 8;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 9;
  localparam int INC_W       = 31;

  // fixed-point time step
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 32;
  localparam int WHOLE_W   = ACC_W + 1 - FRAC_BITS;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_INCREMENT = 1'b1;
  localparam int CFG_DATA_W = 31;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST    = 9'd1;
  localparam logic [INC_W-1:0] TIME_INCREMENT_RST = 31'd65536;

  // request kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // result kinds
  localparam logic EVENT_PLAYED = 1'b0;
  localparam logic EVENT_STOP   = 1'b1;

  // one accepted request as queued between front and back
  typedef struct packed {
    logic                 is_write;
    logic                 play;
    logic [PTR_W-1:0]     index;
    logic [TIME_W-1:0]    etime;
    logic [PIN_COUNT-1:0] bits;
  } cmd_t;

  // one table entry
  typedef struct packed {
    logic [TIME_W-1:0]    due_time;
    logic [PIN_COUNT-1:0] bits;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result beat
  typedef struct packed {
    logic [PIN_COUNT-1:0] pin_bits;
    logic                 event_kind;
    logic [PTR_W-1:0]     played_index;
  } result_t;

  // configuration registers seen by the back end
  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [INC_W-1:0] time_increment;
  } cfg_t;

endpackage

FILE: rtl/tpp_ram.sv
// ----------------------------------------------------------------------------
// tpp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tpp_front.sv
// ----------------------------------------------------------------------------
// tpp_front
// Accepts request beats, sorts them into write and tick commands and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tpp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_req_type,
  input  logic                          in_play,
  input  logic [tpp_pkg::PTR_W-1:0]     in_entry_index,
  input  logic [tpp_pkg::TIME_W-1:0]    in_entry_time,
  input  logic [tpp_pkg::PIN_COUNT-1:0] in_entry_bits,
  output logic                          cmd_valid,
  output tpp_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);
  import tpp_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  // classify the incoming beat; fields that do not apply are cleared
  always_comb begin
    cmd_in          = '0;
    cmd_in.is_write = (in_req_type == REQ_WRITE);
    if (in_req_type == REQ_WRITE) begin
      cmd_in.index = in_entry_index;
      cmd_in.etime = in_entry_time;
      cmd_in.bits  = in_entry_bits;
    end else begin
      cmd_in.play = in_play;
    end
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // queue pointers
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: rtl/tpp_result_queue.sv
// ----------------------------------------------------------------------------
// tpp_result_queue
// Two-entry queue that holds result beats until the receiver pops them.
// ----------------------------------------------------------------------------
module tpp_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_push,
  input  tpp_pkg::result_t res_in,
  output logic             res_full,
  output logic             empty,
  input  logic             pop,
  output tpp_pkg::result_t res_out
);
  import tpp_pkg::*;

  result_t    q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign empty    = (count_r == 2'd0);
  assign res_full = (count_r == 2'd2);
  assign res_out  = q_r[rd_ptr_r];
  assign do_pop   = pop && !empty;
  assign do_push  = res_push && !res_full;

  // queue pointers
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

FILE: rtl/tpp_back.sv
// ----------------------------------------------------------------------------
// tpp_back
// Executes queued commands: table writes, playing ticks that emit due
// entries and advance time, and stopped ticks that clear the player.
// ----------------------------------------------------------------------------
module tpp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tpp_pkg::cfg_t    cfg,
  input  logic             cmd_valid,
  input  tpp_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output tpp_pkg::result_t res_out
);
  import tpp_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [ACC_W:0]   HALF_FX   = (ACC_W+1)'(1) << (FRAC_BITS - 1);

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [TIME_W-1:0] tc_r, tc_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              byp_valid_r, byp_valid_nxt;
  entry_t            byp_entry_r;

  entry_t            rd_data, cur_entry, wr_entry;
  logic [PTR_W-1:0]  raddr;
  logic              go, wr, tick_play, tick_stop, due, wrap, carry;
  logic [CNT_W-1:0]  eff_cnt, ptr_inc;
  logic [ACC_W-1:0]  sum;
  logic [ACC_W:0]    rounded;
  logic [TIME_W-1:0] add_amt, tc_adv;

  // command issue: writes never produce a result, ticks need room for one
  assign go        = cmd_valid && (cmd.is_write || !res_full);
  assign cmd_pop   = go;
  assign wr        = go && cmd.is_write;
  assign tick_play = go && !cmd.is_write && cmd.play;
  assign tick_stop = go && !cmd.is_write && !cmd.play;

  // entry at the read pointer, with the latest write forwarded
  assign cur_entry = byp_valid_r ? byp_entry_r : rd_data;
  assign wr_entry  = '{due_time: cmd.etime, bits: cmd.bits};

  // effective entry count and pointer wrap
  always_comb begin
    if (cfg.entry_count == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (cfg.entry_count > DEPTH_CNT) begin
      eff_cnt = DEPTH_CNT;
    end else begin
      eff_cnt = cfg.entry_count;
    end
    ptr_inc = {1'b0, ptr_r} + CNT_W'(1);
    wrap    = (ptr_inc >= eff_cnt);
    due     = (cur_entry.due_time <= tc_r);
  end

  // fractional time step, rounded half up once a whole unit is reached
  always_comb begin
    sum     = acc_r + {1'b0, cfg.time_increment};
    carry   = (sum[ACC_W-1:FRAC_BITS] != '0);
    rounded = ({1'b0, sum} + HALF_FX) >> FRAC_BITS;
    add_amt = carry ? TIME_W'(rounded[WHOLE_W-1:0]) : '0;
    tc_adv  = tc_r + add_amt;
  end

  // next state of pointer, counter and accumulator
  always_comb begin
    ptr_nxt = ptr_r;
    tc_nxt  = tc_r;
    acc_nxt = acc_r;
    if (tick_play) begin
      acc_nxt = carry ? '0 : sum;
      if (due && wrap) begin
        ptr_nxt = '0;
        tc_nxt  = add_amt;
      end else begin
        tc_nxt = tc_adv;
        if (due) begin
          ptr_nxt = ptr_inc[PTR_W-1:0];
        end
      end
    end else if (tick_stop) begin
      ptr_nxt = '0;
      tc_nxt  = '0;
      acc_nxt = '0;
    end
  end

  // result beat
  always_comb begin
    res_push = (tick_play && due) || (tick_stop && (tc_r != '0));
    res_out  = '0;
    if (tick_play) begin
      res_out.pin_bits     = cur_entry.bits;
      res_out.event_kind   = EVENT_PLAYED;
      res_out.played_index = ptr_r;
    end else begin
      res_out.event_kind = EVENT_STOP;
    end
  end

  // read the entry the pointer will hold next cycle
  assign raddr         = rst_n ? ptr_nxt : '0;
  assign byp_valid_nxt = wr && (cmd.index == raddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      tc_r        <= '0;
      acc_r       <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      tc_r        <= tc_nxt;
      acc_r       <= acc_nxt;
      byp_valid_r <= byp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_entry_r <= wr_entry;
  end

  // event table
  tpp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr),
    .waddr (cmd.index),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_data)
  );

endmodule

FILE: rtl/timestamped_pattern_player_core.sv
// ----------------------------------------------------------------------------
// timestamped_pattern_player_core
// Plays a table of timestamped pin patterns against a fixed-point time base.
//
// Request side is a queue: a beat is taken when push is high and full is
// low. A write beat loads one table entry; a tick beat runs one step of the
// player, playing or stopped. Result side is a queue too: the oldest result
// sits on the out_ ports while empty is low and leaves when pop is high.
// Ticks that emit nothing and write beats produce no result beat.
// One beat is taken every cycle while full is low; a result passes through
// the command queue register and then the result queue register before it
// is on the out_ ports. The read pointer's next value addresses the
// table RAM so the entry at the pointer is read in time for the next tick.
// When the receiver stalls, results wait in a two-entry queue, then ticks
// wait in a two-entry command queue, and full rises. Writes at the head of
// the command queue keep draining.
// The cfg_ port sets entry_count (index 0) and time_increment (index 1);
// the user writes them only while idle; the block does not enforce it.
// Synchronous reset clears pointer, time counter, accumulator, both queues,
// loads the register defaults; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module timestamped_pattern_player_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // request queue
  input  logic                             push,
  output logic                             full,
  input  logic                             in_req_type,
  input  logic                             in_play,
  input  logic [tpp_pkg::PTR_W-1:0]        in_entry_index,
  input  logic [tpp_pkg::TIME_W-1:0]       in_entry_time,
  input  logic [tpp_pkg::PIN_COUNT-1:0]    in_entry_bits,
  // result queue
  output logic                             empty,
  input  logic                             pop,
  output logic [tpp_pkg::PIN_COUNT-1:0]    out_pin_bits,
  output logic                             out_event_kind,
  output logic [tpp_pkg::PTR_W-1:0]        out_played_index,
  // configuration
  input  logic                             cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tpp_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  logic    res_full, res_push;
  result_t res_in, res_out;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT:    cfg_nxt.entry_count    = cfg_data[CNT_W-1:0];
        CFG_TIME_INCREMENT: cfg_nxt.time_increment = cfg_data[INC_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_count    <= ENTRY_COUNT_RST;
      cfg_r.time_increment <= TIME_INCREMENT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request intake
  tpp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_play        (in_play),
    .in_entry_index (in_entry_index),
    .in_entry_time  (in_entry_time),
    .in_entry_bits  (in_entry_bits),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // player engine
  tpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_in)
  );

  // result buffering
  tpp_result_queue u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign out_pin_bits     = res_out.pin_bits;
  assign out_event_kind   = res_out.event_kind;
  assign out_played_index = res_out.played_index;

endmodule
